// File: sv/utcp_pkg.sv
// Package for the text command parser: line store size, command codes, parser states.
// No dependencies.
package utcp_pkg;
    localparam int LINE_MAX = 64;
    localparam int AW = $clog2(LINE_MAX);

    typedef enum logic [1:0] {
        KIND_BRIGHT = 2'd0,
        KIND_COLOR  = 2'd1,
        KIND_DISP   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HDR,
        ST_BWS,
        ST_BSIGN,
        ST_BDIG,
        ST_CSP,
        ST_DSP1,
        ST_DSP2,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] brightness;
        logic [2:0] color;
        logic [7:0] left;
        logic [7:0] right;
    } t_result;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A) begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic logic [2:0] color_bits(input logic [7:0] c);
        logic [7:0] u;
        u = upcase(c);
        case (u)
            8'h52:   return 3'd1;
            8'h47:   return 3'd2;
            8'h42:   return 3'd4;
            8'h43:   return 3'd6;
            8'h4D:   return 3'd5;
            8'h59:   return 3'd3;
            8'h57:   return 3'd7;
            default: return 3'd0;
        endcase
    endfunction
endpackage

// File: sv/utcp_line_ram.sv
// Line store: one-write, one-read synchronous RAM with registered read data.
// Depends on utcp_pkg.
module utcp_line_ram (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [utcp_pkg::AW-1:0] i_waddr,
    input  logic [7:0]              i_wdata,
    input  logic [utcp_pkg::AW-1:0] i_raddr,
    output logic [7:0]              o_rdata
);
    logic [7:0] r_mem [utcp_pkg::LINE_MAX];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/utcp_parser.sv
// Line parser: walks the line store one byte a cycle, bar a re-read bubble; builds the result.
// Depends on utcp_pkg.
module utcp_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [utcp_pkg::AW-1:0] i_len,
    input  logic [7:0]              i_limit,
    output logic [utcp_pkg::AW-1:0] o_raddr,
    input  logic [7:0]              i_rdata,
    output logic                    o_done,
    output logic                    o_hit,
    output utcp_pkg::t_result       o_res,
    output logic                    o_busy
);
    localparam int AW = utcp_pkg::AW;

    utcp_pkg::t_state r_st, n_st;
    logic [AW:0]  r_pos, n_pos;     // position of the byte in i_rdata
    logic [AW-1:0] r_len, n_len;    // length of the line being walked
    logic [3:0]   r_mb, n_mb;       // header match flags: B, BRIGHTNESS; upper bits unused
    logic [8:0]   r_val, n_val;
    logic         r_dig, n_dig;
    logic         r_neg, n_neg;
    logic [7:0]   r_left, n_left;
    logic         r_hit, n_hit;
    utcp_pkg::t_result r_res, n_res;
    logic [3:0]   r_mc, n_mc;       // C, COLOR, D, SSD
    logic         have;
    logic [7:0]   c;
    logic [AW:0]  rpos;
    logic [12:0]  v10;

    assign c    = i_rdata;
    assign have = r_pos < {1'b0, r_len};
    assign o_raddr = rpos[AW-1:0];
    assign o_done = (r_st == utcp_pkg::ST_OUT);
    assign o_hit  = r_hit;
    assign o_res  = r_res;
    assign o_busy = (r_st != utcp_pkg::ST_IDLE);
    assign v10 = {4'd0, r_val} * 13'd10 + {9'd0, c[3:0]};

    // header words, first character in the top byte
    function automatic logic [7:0] hdr(input logic [2:0] k, input logic [AW:0] p);
        logic [87:0] w;
        case (k)
            3'd0:    w = {"B ", 72'd0};
            3'd1:    w = "BRIGHTNESS ";
            3'd2:    w = {"C ", 72'd0};
            3'd3:    w = {"COLOR ", 40'd0};
            3'd4:    w = {"SSD", 64'd0};
            default: w = '0;
        endcase
        if (p < 11) begin
            return w[8*(10 - int'(p)) +: 8];
        end
        return 8'h00;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= utcp_pkg::ST_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_pos <= n_pos; r_mb <= n_mb; r_mc <= n_mc; r_val <= n_val;
        r_dig <= n_dig; r_neg <= n_neg; r_left <= n_left; r_hit <= n_hit;
        r_res <= n_res; r_len <= n_len;
    end

    always_comb begin
        n_st = r_st; n_pos = r_pos; n_mb = r_mb; n_mc = r_mc; n_val = r_val;
        n_dig = r_dig; n_neg = r_neg; n_left = r_left; n_hit = r_hit; n_res = r_res;
        n_len = r_len;
        rpos = r_pos + 1'b1;
        unique case (r_st)
            utcp_pkg::ST_IDLE: begin
                rpos = '0;
                if (i_start) begin
                    n_st = utcp_pkg::ST_HDR; n_pos = '0; n_len = i_len;
                    n_mb = 4'hF; n_mc = 4'hF; n_hit = 1'b0;
                    n_res = '0; n_val = '0; n_dig = 1'b0; n_neg = 1'b0;
                end
            end
            utcp_pkg::ST_HDR: begin
                // header compare over the first 11 bytes; a short line fails pending words
                if (!(have && c == hdr(3'd0, r_pos)) && r_pos < 2)  n_mb[0] = 1'b0;
                if (!(have && c == hdr(3'd1, r_pos)) && r_pos < 11) n_mb[1] = 1'b0;
                if (!(have && c == hdr(3'd2, r_pos)) && r_pos < 2)  n_mc[0] = 1'b0;
                if (!(have && c == hdr(3'd3, r_pos)) && r_pos < 6)  n_mc[1] = 1'b0;
                if (!(have && c == 8'h44) && r_pos == 0)            n_mc[2] = 1'b0;
                if (!(have && c == hdr(3'd4, r_pos)) && r_pos < 3)  n_mc[3] = 1'b0;
                n_pos = r_pos + 1'b1;
                if (r_pos == 10) begin
                    // B wins, then C, then D; resume at each word's end
                    if (n_mb[0] || n_mb[1]) begin
                        n_st = utcp_pkg::ST_BWS;
                        n_pos = n_mb[0] ? (AW+1)'(2) : (AW+1)'(11);
                    end else if (n_mc[0] || n_mc[1]) begin
                        n_st = utcp_pkg::ST_CSP;
                        n_pos = n_mc[0] ? (AW+1)'(2) : (AW+1)'(6);
                    end else if (n_mc[2] || n_mc[3]) begin
                        n_st = utcp_pkg::ST_DSP1;
                        n_pos = n_mc[2] ? (AW+1)'(1) : (AW+1)'(3);
                    end else begin
                        n_st = utcp_pkg::ST_OUT;
                    end
                    rpos = n_pos;
                end
            end
            utcp_pkg::ST_BWS: begin
                n_pos = r_pos + 1'b1;
                if (!(have && (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)))) begin
                    if (have && (c == 8'h2B || c == 8'h2D)) begin
                        n_neg = (c == 8'h2D);
                    end else begin
                        n_pos = r_pos; rpos = r_pos + 1'b1;
                    end
                    n_st = utcp_pkg::ST_BDIG;
                    if (n_pos == r_pos) begin
                        // reuse current byte: hold address on it
                        rpos = r_pos;
                        n_st = utcp_pkg::ST_BSIGN;
                    end
                end
            end
            utcp_pkg::ST_BSIGN: begin
                // bubble state to re-read the current byte
                n_st = utcp_pkg::ST_BDIG;
                rpos = r_pos;
            end
            utcp_pkg::ST_BDIG: begin
                n_pos = r_pos + 1'b1;
                if (have && c >= 8'h30 && c <= 8'h39) begin
                    n_dig = 1'b1;
                    n_val = (v10 > 13'd256) ? 9'd256 : v10[8:0];
                end else begin
                    n_st = utcp_pkg::ST_OUT;
                    n_res.kind = utcp_pkg::KIND_BRIGHT;
                    n_res.brightness = r_val[7:0];
                    n_hit = r_dig && !(r_neg && r_val != 0) && r_val <= {1'b0, i_limit};
                end
            end
            utcp_pkg::ST_CSP: begin
                n_pos = r_pos + 1'b1;
                if (!(have && c == 8'h20)) begin
                    n_st = utcp_pkg::ST_OUT;
                    n_res.kind = utcp_pkg::KIND_COLOR;
                    n_res.color = have ? utcp_pkg::color_bits(c) : 3'd0;
                    n_hit = have && n_res.color != 0;
                end
            end
            utcp_pkg::ST_DSP1: begin
                n_pos = r_pos + 1'b1;
                if (!(have && c == 8'h20)) begin
                    n_left = utcp_pkg::upcase(c);
                    n_st = have ? utcp_pkg::ST_DSP2 : utcp_pkg::ST_OUT;
                end
            end
            utcp_pkg::ST_DSP2: begin
                n_pos = r_pos + 1'b1;
                if (!(have && c == 8'h20)) begin
                    n_st = utcp_pkg::ST_OUT;
                    n_hit = 1'b1;
                    n_res.kind = utcp_pkg::KIND_DISP;
                    n_res.left = r_left;
                    n_res.right = have ? utcp_pkg::upcase(c) : r_left;
                end
            end
            utcp_pkg::ST_OUT: begin
                n_st = utcp_pkg::ST_IDLE;
            end
            default: n_st = utcp_pkg::ST_IDLE;
        endcase
    end
endmodule

// File: sv/uart_text_command_parser.sv
// Top level of the text command parser: byte intake, line length, output register.
// Depends on utcp_pkg, utcp_line_ram, utcp_parser.
//
// Usage:
//  - Input channel i_valid/o_stall carries one received byte (i_rx_byte) per
//    transaction. Ordinary bytes are written into the line store.
//  - CR or LF ends the line. A non-empty line is parsed by walking the store
//    one byte a cycle through the RAM read port, but for a bubble where a
//    byte is re-read: the 11 header bytes first, then the arguments. Input
//    stalls while the walk runs.
//  - A recognized command gives one transaction on o_valid/i_stall with
//    o_cmd_kind, o_brightness, o_color_code, o_left_code, o_right_code,
//    registered from the result when the walk ends; fields not used by the
//    kind read 0. Other lines give nothing.
//  - The result sits in an output register; a stalled result holds and the
//    next byte is still taken, but a new line end waits until it leaves.
//  - Config channel i_cfg_valid/o_cfg_ready writes brightness_limit, always
//    ready. Reset sets it to 25 and empties the line; store content is
//    left as is and a byte is never used before being written.
//  - A byte other than CR or LF that arrives with LINE_MAX-1 bytes stored drops the line.
module uart_text_command_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_cmd_kind,
    output logic [7:0] o_brightness,
    output logic [2:0] o_color_code,
    output logic [7:0] o_left_code,
    output logic [7:0] o_right_code,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    localparam int AW = utcp_pkg::AW;

    logic [7:0]    r_limit;
    logic [AW-1:0] r_len;
    logic          r_oval;
    utcp_pkg::t_result r_out;
    logic          acc, eol, busy, done, hit, start;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    utcp_pkg::t_result res;

    assign o_cfg_ready = 1'b1;
    assign eol   = (i_rx_byte == 8'h0D) || (i_rx_byte == 8'h0A);
    // line end waits for a free output register
    assign o_stall = busy || (eol && r_oval);
    assign acc   = i_valid && !o_stall;
    assign start = acc && eol && (r_len != 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 8'd25;
            r_len   <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (acc) begin
                if (eol || r_len == AW'(utcp_pkg::LINE_MAX - 1)) begin
                    r_len <= '0;
                end else begin
                    r_len <= r_len + 1'b1;
                end
            end
            if (done && hit) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
        end
        if (done && hit) begin
            r_out <= res;
        end
    end

    utcp_line_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (acc && !eol && r_len != AW'(utcp_pkg::LINE_MAX - 1)),
        .i_waddr (r_len),
        .i_wdata (i_rx_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    utcp_parser u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_len   (r_len),
        .i_limit (r_limit),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_done  (done),
        .o_hit   (hit),
        .o_res   (res),
        .o_busy  (busy)
    );

    assign o_valid      = r_oval;
    assign o_cmd_kind   = r_out.kind;
    assign o_brightness = r_out.brightness;
    assign o_color_code = r_out.color;
    assign o_left_code  = r_out.left;
    assign o_right_code = r_out.right;
endmodule
